FILE: hw/rtl/brf_pkg.sv
package brf_pkg;

  // Storage and request geometry.
  localparam int DEPTH     = 256;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CAP_W     = PTR_W + 1;
  localparam int MAX_BURST = 8;
  localparam int LEN_W     = 4;
  localparam int IDX_W     = 3;
  localparam int DATA_W    = 64;

  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(DEPTH);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

  typedef enum logic [1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_STATUS = 2'd3
  } brf_func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP,
    ST_DONE
  } brf_state_e;

  // Result of one transaction as handed from the sequencer to the output stage.
  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_data;
    logic [PTR_W-1:0]  used_count;
    logic [PTR_W-1:0]  free_count;
  } brf_res_t;

  // Advance a pointer by one slot, wrapping at the active capacity.
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] inc;
    inc = {1'b0, p} + CAP_W'(1);
    return (inc >= cap) ? '0 : inc[PTR_W-1:0];
  endfunction

  // Bring a written capacity into the supported range.
  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] r;
    r = c;
    if (c < CAP_MIN) r = CAP_MIN;
    if (c > CAP_MAX) r = CAP_MAX;
    return r;
  endfunction

endpackage

FILE: hw/rtl/brf_req_if.sv
interface brf_req_if import brf_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [LEN_W-1:0]  length;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, output func, output length, output write_data,
                  input ready);
  modport sink (input valid, input func, input length, input write_data,
                output ready);

endinterface

FILE: hw/rtl/brf_rsp_if.sv
interface brf_rsp_if import brf_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              ok;
  logic [DATA_W-1:0] read_data;
  logic [PTR_W-1:0]  used_count;
  logic [PTR_W-1:0]  free_count;

  modport source (output valid, output ok, output read_data, output used_count,
                  output free_count, input ready);
  modport sink (input valid, input ok, input read_data, input used_count,
                input free_count, output ready);

endinterface

FILE: hw/rtl/byte_ring_fifo_core.sv
// Circular byte FIFO that keeps one slot empty, so a capacity of N stores at most
// N-1 bytes. Each request pushes, pops, clears or only reports status, and every
// request gives one response with the success flag, popped bytes and the used and
// free counts afterwards. Push and pop move 1 to 8 bytes and are all-or-nothing.
// The storage is a single byte-wide RAM with one write and one registered read
// port, so push and pop move their bytes one at a time, while a clear, a status
// query or a rejected request moves none. A request is taken only after the one
// before has passed its result on, but a new request is taken while an earlier
// response still waits in the output register. Writing the capacity register
// empties the FIFO; values below 2 act as 2 and values above 256 act as 256.
// Write it only while no request is in flight.
module byte_ring_fifo_core import brf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  brf_req_if.sink          req_i,
  brf_rsp_if.source        rsp_o
);

  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic [PTR_W-1:0] mem_raddr;
  logic [7:0]       mem_rdata;
  logic             res_valid;
  logic             res_ready;
  brf_res_t         res;
  logic             out_valid_q, out_valid_d;
  brf_res_t         out_q;

  brf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  brf_ram #(
    .ADDR_W (PTR_W),
    .DATA_W (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The output register frees up in the same cycle its transaction completes.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  // Response channel.
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.ok         = out_q.ok;
  assign rsp_o.read_data  = out_q.read_data;
  assign rsp_o.used_count = out_q.used_count;
  assign rsp_o.free_count = out_q.free_count;

endmodule

FILE: hw/rtl/brf_ram.sv
module brf_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hw/rtl/brf_seq.sv
module brf_seq import brf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  brf_req_if.sink          req_i,
  output logic             mem_we_o,
  output logic [PTR_W-1:0] mem_waddr_o,
  output logic [7:0]       mem_wdata_o,
  output logic [PTR_W-1:0] mem_raddr_o,
  input  logic [7:0]       mem_rdata_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output brf_res_t         res_o
);

  brf_state_e state_q, state_d;

  logic [CAP_W-1:0]  cap_q, cap_d;
  logic [PTR_W-1:0]  rp_q, rp_d;
  logic [PTR_W-1:0]  wp_q, wp_d;
  logic [PTR_W-1:0]  used_q, used_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [DATA_W-1:0] wdata_q, wdata_d;
  logic [DATA_W-1:0] rdata_q;
  logic              ok_q, ok_d;
  logic              rd_pend_q;
  logic [IDX_W-1:0]  rd_idx_q;

  logic             accept;
  logic             len_valid;
  logic             last_byte;
  logic [CAP_W-1:0] room;
  brf_func_e        func;

  assign func      = brf_func_e'(req_i.func);
  assign accept    = req_i.valid && req_i.ready;
  assign room      = cap_q - CAP_W'(1) - {1'b0, used_q};
  assign len_valid = (req_i.length != '0) && (req_i.length <= LEN_W'(MAX_BURST));
  assign last_byte = ({1'b0, cnt_q} == (len_q - LEN_W'(1)));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DONE;
          unique case (func)
            FUNC_PUSH: begin
              if (len_valid && ({5'b0, req_i.length} <= room)) state_d = ST_PUSH;
            end
            FUNC_POP: begin
              if (len_valid && ({5'b0, req_i.length} <= {1'b0, used_q})) begin
                state_d = ST_POP;
              end
            end
            FUNC_CLEAR, FUNC_STATUS: state_d = ST_DONE;
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_PUSH: if (last_byte) state_d = ST_DONE;
      ST_POP:  if (last_byte) state_d = ST_DONE;
      ST_DONE: if (res_valid_o && res_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and storage port outputs.
  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_DONE) && !rd_pend_q;
    mem_we_o    = (state_q == ST_PUSH);
    mem_waddr_o = wp_q;
    mem_wdata_o = wdata_q[8*cnt_q +: 8];
    mem_raddr_o = rp_q;
  end

  // Pointers, counts and the latched request.
  always_comb begin
    cap_d   = cap_q;
    rp_d    = rp_q;
    wp_d    = wp_q;
    used_d  = used_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    wdata_d = wdata_q;
    ok_d    = ok_q;
    if (cfg_we_i) begin
      cap_d  = clamp_cap(cfg_wdata_i);
      rp_d   = '0;
      wp_d   = '0;
      used_d = '0;
    end else if (accept) begin
      cnt_d   = '0;
      len_d   = req_i.length;
      wdata_d = req_i.write_data;
      ok_d    = (state_d != ST_DONE) || (func == FUNC_CLEAR) || (func == FUNC_STATUS);
      if (func == FUNC_CLEAR) begin
        rp_d   = '0;
        wp_d   = '0;
        used_d = '0;
      end
    end else if (state_q == ST_PUSH) begin
      wp_d   = next_ptr(wp_q, cap_q);
      used_d = used_q + PTR_W'(1);
      cnt_d  = cnt_q + IDX_W'(1);
    end else if (state_q == ST_POP) begin
      rp_d   = next_ptr(rp_q, cap_q);
      used_d = used_q - PTR_W'(1);
      cnt_d  = cnt_q + IDX_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cap_q     <= CAP_RESET;
      rp_q      <= '0;
      wp_q      <= '0;
      used_q    <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cap_q     <= cap_d;
      rp_q      <= rp_d;
      wp_q      <= wp_d;
      used_q    <= used_d;
      rd_pend_q <= (state_q == ST_POP);
    end
  end

  // Payload registers; each popped byte goes from the RAM's registered read port into its lane of the read data.
  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    len_q    <= len_d;
    wdata_q  <= wdata_d;
    ok_q     <= ok_d;
    rd_idx_q <= cnt_q;
    if (accept) begin
      rdata_q <= '0;
    end else if (rd_pend_q) begin
      rdata_q[8*rd_idx_q +: 8] <= mem_rdata_i;
    end
  end

  // Result fields.
  always_comb begin
    res_o.ok         = ok_q;
    res_o.read_data  = rdata_q;
    res_o.used_count = used_q;
    res_o.free_count = room[PTR_W-1:0];
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench import brf_pkg::*; ();

  // One request as queued for the driver.
  typedef struct {
    brf_func_e         op;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } fifo_request_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;

  brf_req_if req_if ();
  brf_rsp_if rsp_if ();

  byte_ring_fifo_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Requests not yet taken by the block, and results still owed by it.
  fifo_request_t queued_requests[$];
  brf_res_t      fifo_results_due[$];

  // Mirror of the block's storage, pointers and capacity register.
  logic [7:0]       mirror_bytes [DEPTH];
  int unsigned      mirror_rd;
  int unsigned      mirror_wr;
  logic [CAP_W-1:0] mirror_cap;

  int error_count;
  int send_idle_pct;
  int recv_idle_pct;
  int rsp_stall_left;
  bit req_taken;

  // 20 ns clock.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Bytes held by the mirror for a given effective capacity.
  function automatic int unsigned mirror_used(input int unsigned cap);
    if (mirror_wr >= mirror_rd) return mirror_wr - mirror_rd;
    return cap - (mirror_rd - mirror_wr);
  endfunction

  // Apply one request to the mirror and return the response it must give.
  function automatic brf_res_t predict_fifo_result(input brf_func_e op,
                                                   input logic [LEN_W-1:0] len,
                                                   input logic [DATA_W-1:0] data);
    brf_res_t    res;
    int unsigned cap;
    int unsigned used;
    int unsigned room;
    cap = 32'(mirror_cap);
    if (cap < 32'(CAP_MIN)) cap = 32'(CAP_MIN);
    if (cap > 32'(DEPTH)) cap = 32'(DEPTH);
    if (mirror_rd >= cap) mirror_rd = 0;
    if (mirror_wr >= cap) mirror_wr = 0;
    used = mirror_used(cap);
    room = cap - 1 - used;
    res = '0;
    case (op)
      FUNC_PUSH: begin
        if (len != 0 && len <= MAX_BURST && len <= room) begin
          for (int i = 0; i < len; i++) begin
            mirror_bytes[mirror_wr] = data[8*i +: 8];
            mirror_wr = (mirror_wr + 1 >= cap) ? 0 : mirror_wr + 1;
          end
          res.ok = 1'b1;
        end
      end
      FUNC_POP: begin
        if (len != 0 && len <= MAX_BURST && len <= used) begin
          for (int i = 0; i < len; i++) begin
            res.read_data[8*i +: 8] = mirror_bytes[mirror_rd];
            mirror_rd = (mirror_rd + 1 >= cap) ? 0 : mirror_rd + 1;
          end
          res.ok = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        mirror_rd = 0;
        mirror_wr = 0;
        res.ok = 1'b1;
      end
      default: begin
        res.ok = 1'b1;
      end
    endcase
    used = mirror_used(cap);
    room = cap - 1 - used;
    res.used_count = PTR_W'(used);
    res.free_count = PTR_W'(room);
    return res;
  endfunction

  // Request driver: holds an offer until the block takes it.
  always @(negedge clk_i) begin
    if (!req_if.valid || req_taken) begin
      req_taken = 1'b0;
      if (rst_ni && queued_requests.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        req_if.valid      <= 1'b1;
        req_if.func       <= queued_requests[0].op;
        req_if.length     <= queued_requests[0].len;
        req_if.write_data <= queued_requests[0].data;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response receiver: random back-pressure, or a long hold-off when asked.
  always @(negedge clk_i) begin
    if (rsp_stall_left > 0) begin
      rsp_stall_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: check each response, then predict for each accepted request.
  always @(posedge clk_i) begin
    brf_res_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (fifo_results_due.size() == 0) begin
          $display("%0t: response with no request outstanding", $time);
          error_count++;
        end else begin
          want = fifo_results_due.pop_front();
          if (rsp_if.ok !== want.ok) begin
            $display("%0t: ok mismatch, expected %0d, actual %0d",
                     $time, want.ok, rsp_if.ok);
            error_count++;
          end
          if (rsp_if.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch, expected %h, actual %h",
                     $time, want.read_data, rsp_if.read_data);
            error_count++;
          end
          if (rsp_if.used_count !== want.used_count) begin
            $display("%0t: used_count mismatch, expected %0d, actual %0d",
                     $time, want.used_count, rsp_if.used_count);
            error_count++;
          end
          if (rsp_if.free_count !== want.free_count) begin
            $display("%0t: free_count mismatch, expected %0d, actual %0d",
                     $time, want.free_count, rsp_if.free_count);
            error_count++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        fifo_results_due.push_back(predict_fifo_result(brf_func_e'(req_if.func),
                                                       req_if.length,
                                                       req_if.write_data));
        void'(queued_requests.pop_front());
        req_taken = 1'b1;
      end
    end
  end

  task automatic queue_request(input brf_func_e op, input logic [LEN_W-1:0] len,
                               input logic [DATA_W-1:0] data);
    fifo_request_t item;
    item.op   = op;
    item.len  = len;
    item.data = data;
    queued_requests.push_back(item);
  endtask

  // Hold the sender back until every request has been answered.
  task automatic wait_drained();
    while (queued_requests.size() != 0 || fifo_results_due.size() != 0)
      @(posedge clk_i);
  endtask

  // Capacity write; the block and the mirror both empty the FIFO.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    mirror_cap = value;
    mirror_rd  = 0;
    mirror_wr  = 0;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stimulus: directed corner cases, then random phases over several capacities.
  initial begin
    logic [CAP_W-1:0]  phase_caps [9];
    logic [CAP_W-1:0]  cap_val;
    brf_func_e         op;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    int                pick;
    bit                filling;

    phase_caps = '{9'd1, 9'd3, 9'd256, 9'd17, 9'd511, 9'd257, 9'd2, 9'd9, 9'd100};
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.func       = FUNC_PUSH;
    req_if.length     = '0;
    req_if.write_data = '0;
    rsp_if.ready      = 1'b0;
    error_count       = 0;
    rsp_stall_left    = 0;
    send_idle_pct     = 37;
    recv_idle_pct     = 88;
    req_taken         = 1'b0;
    mirror_cap        = CAP_RESET;
    mirror_rd         = 0;
    mirror_wr         = 0;
    foreach (mirror_bytes[i]) mirror_bytes[i] = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset capacity: rejects, ignored upper bytes, clear.
    queue_request(FUNC_STATUS, 4'd0, '0);
    queue_request(FUNC_POP, 4'd1, '0);
    queue_request(FUNC_PUSH, 4'd0, 64'h0123_4567_89AB_CDEF);
    queue_request(FUNC_PUSH, 4'd9, 64'h0123_4567_89AB_CDEF);
    queue_request(FUNC_PUSH, 4'd15, '1);
    queue_request(FUNC_PUSH, 4'd8, '1);
    queue_request(FUNC_PUSH, 4'd1, 64'hFFFF_FFFF_FFFF_FF00);
    queue_request(FUNC_PUSH, 4'd3, 64'hFFFF_FFFF_FFC3_5AA5);
    queue_request(FUNC_POP, 4'd0, '1);
    queue_request(FUNC_POP, 4'd9, '0);
    queue_request(FUNC_POP, 4'd8, '0);
    queue_request(FUNC_POP, 4'd5, '0);
    queue_request(FUNC_POP, 4'd4, '0);
    queue_request(FUNC_PUSH, 4'd8, {$urandom, $urandom});
    queue_request(FUNC_CLEAR, 4'd15, '1);
    queue_request(FUNC_STATUS, 4'd8, '1);
    queue_request(FUNC_POP, 4'd1, '0);
    wait_drained();

    // Smallest storage: one usable byte, written as zero to hit the clamp.
    write_capacity(9'd0);
    queue_request(FUNC_PUSH, 4'd2, 64'h0000_0000_0000_BEEF);
    queue_request(FUNC_PUSH, 4'd1, 64'h0000_0000_0000_005A);
    queue_request(FUNC_PUSH, 4'd1, 64'h0000_0000_0000_00A5);
    queue_request(FUNC_POP, 4'd1, '0);
    queue_request(FUNC_POP, 4'd1, '0);
    wait_drained();

    // Random phases: fill-heavy stretches followed by drain-heavy ones.
    for (int phase = 0; phase < 9; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 88;
      end else if (phase < 6) begin
        send_idle_pct = 88;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cap_val = (phase == 6) ? CAP_W'($urandom_range(255, 2)) : phase_caps[phase];
      write_capacity(cap_val);

      for (int k = 0; k < 170; k++) begin
        filling = (k % 120) < 70;
        pick = $urandom_range(99);
        if (filling)
          op = (pick < 90) ? FUNC_PUSH : (pick < 95) ? FUNC_POP : FUNC_STATUS;
        else
          op = (pick < 80) ? FUNC_POP : (pick < 92) ? FUNC_PUSH :
               (pick < 98) ? FUNC_STATUS : FUNC_CLEAR;
        pick = $urandom_range(99);
        if (pick < 85) len = LEN_W'($urandom_range(8, 1));
        else if (pick < 93) len = '0;
        else len = LEN_W'($urandom_range(15, 9));
        pick = $urandom_range(99);
        if (pick < 10) data = '1;
        else if (pick < 15) data = '0;
        else data = {$urandom, $urandom};
        queue_request(op, len, data);
      end

      // Long receiver hold-off so the block backs up and stalls its input.
      if (phase == 1 || phase == 7) begin
        @(posedge clk_i);
        rsp_stall_left = 400;
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: byte_ring_fifo_core.f
hw/rtl/brf_pkg.sv
hw/rtl/brf_req_if.sv
hw/rtl/brf_rsp_if.sv
hw/rtl/brf_ram.sv
hw/rtl/brf_seq.sv
hw/rtl/byte_ring_fifo_core.sv
bench/testbench.sv
